>>> design/sdf_pkg.sv
package sdf_pkg;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_EMPTY_SET = 2'd2;
	localparam logic [1:0] ST_STORE_FULL = 2'd3;

	// Request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TEST = 1'b1;

	// Fixed field widths
	localparam int VAL_W = 32;
	localparam int CAP_W = 9;
	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	// One word slot as it moves down the cell chain
	typedef struct packed {
		logic             valid;
		logic             req;      // REQ_LOAD or REQ_TEST
		logic             last;
		logic             load_ok;  // load had room in the store at entry
		logic             match;    // a stored word equaled this test word so far
		logic [VAL_W-1:0] word;
	} slot_t;

endpackage

>>> design/sdf_cell.sv
module sdf_cell #(
	parameter int IDX       = 0,
	parameter int WORD_BITS = 32,
	parameter int CNT_W     = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  sdf_pkg::slot_t       slot_in,
	input  logic [WORD_BITS-1:0] cmp_in,
	input  logic [CNT_W-1:0]     snap_in,
	output sdf_pkg::slot_t       slot_out,
	output logic [WORD_BITS-1:0] cmp_out,
	output logic [CNT_W-1:0]     snap_out
);

	logic [WORD_BITS-1:0] stored_q;
	sdf_pkg::slot_t       slot_q;
	logic [WORD_BITS-1:0] cmp_q;
	logic [CNT_W-1:0]     snap_q;
	logic                 in_set;
	logic                 hit;
	logic                 wr_en;

	// This entry counts only if it was below the store count when the word entered
	assign in_set = (snap_in > CNT_W'(IDX));
	assign hit    = slot_in.valid && (slot_in.req == sdf_pkg::REQ_TEST) && in_set &&
	                (stored_q == cmp_in);
	assign wr_en  = adv && slot_in.valid && (slot_in.req == sdf_pkg::REQ_LOAD) &&
	                slot_in.load_ok && (snap_in == CNT_W'(IDX));

	// Stored exclusion word, written as its load passes by
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stored_q <= cmp_in;
		end
	end

	// Slot handed to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (adv) begin
			slot_q.valid   <= slot_in.valid;
			slot_q.req     <= slot_in.req;
			slot_q.last    <= slot_in.last;
			slot_q.load_ok <= slot_in.load_ok;
			slot_q.match   <= slot_in.match | hit;
			slot_q.word    <= slot_in.word;
		end
	end

	// Compare word and store count snapshot
	always_ff @(posedge clk) begin
		if (adv) begin
			cmp_q  <= cmp_in;
			snap_q <= snap_in;
		end
	end

	assign slot_out = slot_q;
	assign cmp_out  = cmp_q;
	assign snap_out = snap_q;

endmodule

>>> design/sdf_tail.sv
module sdf_tail #(
	parameter int CNT_W = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [sdf_pkg::CAP_W-1:0]     cap,
	input  sdf_pkg::slot_t                slot_in,
	input  logic [CNT_W-1:0]              snap_in,
	input  logic                          out_taken,
	output logic                          out_valid,
	output logic [sdf_pkg::VAL_W-1:0]     kept_value,
	output logic                          kept,
	output logic [sdf_pkg::CAP_W-1:0]     kept_count,
	output logic [1:0]                    status,
	output logic                          job_done
);

	logic [sdf_pkg::CAP_W-1:0] kept_q;
	logic [1:0]                err_q;
	logic                      valid_q;
	logic [sdf_pkg::VAL_W-1:0] kv_q;
	logic                      kp_q;
	logic [sdf_pkg::CAP_W-1:0] cnt_q;
	logic [1:0]                st_q;
	logic                      done_q;

	logic                      is_test;
	logic                      emit;
	logic [1:0]                err_nx;
	logic [sdf_pkg::CAP_W-1:0] kept_nx;
	logic                      kp_nx;

	assign is_test = (slot_in.req == sdf_pkg::REQ_TEST);
	assign emit    = slot_in.valid && (is_test || !slot_in.load_ok);

	// Decision for a test word that has passed every cell
	always_comb begin
		err_nx  = err_q;
		kept_nx = kept_q;
		kp_nx   = 1'b0;
		if (err_q == sdf_pkg::ST_OK) begin
			if (snap_in == '0) begin
				err_nx = sdf_pkg::ST_EMPTY_SET;
			end else if (cap == '0) begin
				err_nx = sdf_pkg::ST_OVERFLOW;
			end else if (!slot_in.match) begin
				if (kept_q >= cap) begin
					err_nx = sdf_pkg::ST_OVERFLOW;
				end else begin
					kept_nx = kept_q + sdf_pkg::CAP_W'(1);
					kp_nx   = 1'b1;
				end
			end
		end
	end

	// Job state and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q  <= '0;
			err_q   <= sdf_pkg::ST_OK;
			valid_q <= 1'b0;
		end else begin
			if (adv) begin
				valid_q <= emit;
				if (slot_in.valid && is_test) begin
					if (slot_in.last) begin
						kept_q <= '0;
						err_q  <= sdf_pkg::ST_OK;
					end else begin
						kept_q <= kept_nx;
						err_q  <= err_nx;
					end
				end
			end else if (out_taken) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output word fields
	always_ff @(posedge clk) begin
		if (adv && emit) begin
			if (is_test) begin
				kv_q   <= kp_nx ? slot_in.word : '0;
				kp_q   <= kp_nx;
				cnt_q  <= kept_nx;
				st_q   <= err_nx;
				done_q <= slot_in.last;
			end else begin
				kv_q   <= '0;
				kp_q   <= 1'b0;
				cnt_q  <= kept_q;
				st_q   <= sdf_pkg::ST_STORE_FULL;
				done_q <= 1'b0;
			end
		end
	end

	assign out_valid  = valid_q;
	assign kept_value = kv_q;
	assign kept       = kp_q;
	assign kept_count = cnt_q;
	assign status     = st_q;
	assign job_done   = done_q;

endmodule

>>> design/set_difference_filter.sv
// Set-difference membership filter.
// Slave channel s_*: one word per item. s_tuser selects the request (0 load an
// exclusion word, 1 test a word), s_tdata carries the word, s_tlast marks the
// last test word of a job. Loads that find room produce no output word; every
// test, and every load into a full store, produces one word on m_*.
// Config channel cfg_*: writes dest_capacity, always ready; write only while idle.
// Items flow down a chain of SET_DEPTH cells, one cell per cycle while the chain is
// not frozen, each cell holding one exclusion word and comparing it with passing test
// words. An item passes the cell registers and then the tail's output register before
// m_tvalid; one item is accepted every cycle while the chain advances as a whole.
// When the output word is not taken the whole chain freezes and s_tready drops
// until m_tready frees the output register.
// Reset empties the chain and clears store count, kept count and error status;
// dest_capacity returns to 256. Stored words need no clearing.
// A test with s_tlast set ends the job: store count, kept count and error clear.
module set_difference_filter #(
	parameter int SET_DEPTH = 256,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] word_value
	input  logic        s_tuser,   // [0] req_type
	input  logic        s_tlast,   // last_item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] kept_value, [32] kept, [41:33] kept_count,
	                               // [43:42] status, [47:44] zero
	output logic        m_tlast,   // job_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data   // dest_capacity
);

	localparam int CNT_W = $clog2(SET_DEPTH + 1);
	localparam int EXT_W = (WORD_BITS > sdf_pkg::VAL_W) ? WORD_BITS : sdf_pkg::VAL_W;

	logic [sdf_pkg::CAP_W-1:0] cap_q;
	logic [CNT_W-1:0]          count_q;
	logic                      adv;
	logic                      room;
	logic [EXT_W-1:0]          word_ext;

	sdf_pkg::slot_t            slot_w [SET_DEPTH+1];
	logic [WORD_BITS-1:0]      cmp_w  [SET_DEPTH+1];
	logic [CNT_W-1:0]          snap_w [SET_DEPTH+1];

	logic                      out_valid;
	logic [sdf_pkg::VAL_W-1:0] kept_value;
	logic                      kept;
	logic [sdf_pkg::CAP_W-1:0] kept_count;
	logic [1:0]                status;
	logic                      job_done;

	// Chain moves when the output register is free or being emptied
	assign adv       = !out_valid || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= sdf_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// Store fill count, tracked at chain entry
	assign room = (count_q < CNT_W'(SET_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (s_tvalid && adv) begin
			if (s_tuser == sdf_pkg::REQ_LOAD) begin
				if (room) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (s_tlast) begin
				count_q <= '0;
			end
		end
	end

	// Entry slot
	assign word_ext = EXT_W'(s_tdata);

	always_comb begin
		slot_w[0].valid   = s_tvalid;
		slot_w[0].req     = s_tuser;
		slot_w[0].last    = s_tlast;
		slot_w[0].load_ok = room;
		slot_w[0].match   = 1'b0;
		slot_w[0].word    = s_tdata;
	end
	assign cmp_w[0]  = word_ext[WORD_BITS-1:0];
	assign snap_w[0] = count_q;

	// Cell chain
	for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
		sdf_cell #(
			.IDX       (i),
			.WORD_BITS (WORD_BITS),
			.CNT_W     (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.slot_in  (slot_w[i]),
			.cmp_in   (cmp_w[i]),
			.snap_in  (snap_w[i]),
			.slot_out (slot_w[i+1]),
			.cmp_out  (cmp_w[i+1]),
			.snap_out (snap_w[i+1])
		);
	end

	// Decision and output register
	sdf_tail #(
		.CNT_W (CNT_W)
	) u_tail (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.cap        (cap_q),
		.slot_in    (slot_w[SET_DEPTH]),
		.snap_in    (snap_w[SET_DEPTH]),
		.out_taken  (m_tready),
		.out_valid  (out_valid),
		.kept_value (kept_value),
		.kept       (kept),
		.kept_count (kept_count),
		.status     (status),
		.job_done   (job_done)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = {4'b0000, status, kept_count, kept, kept_value};
	assign m_tlast  = job_done;

endmodule
